[sv/dfcc_pkg.sv]
package dfcc_pkg;

    localparam int          FRAME_LEN   = 8;
    localparam int          CNT_W       = $clog2(FRAME_LEN);
    localparam logic [7:0]  DELIM_RESET = 8'h24;
    localparam logic [15:0] CRC_HI_MASK = 16'hFF00;

    // frame byte positions
    localparam logic [CNT_W-1:0] POS_ZERO_BYTE = CNT_W'(1);
    localparam logic [CNT_W-1:0] POS_CRC_LO    = CNT_W'(2);
    localparam logic [CNT_W-1:0] POS_CRC_HI    = CNT_W'(3);
    localparam logic [CNT_W-1:0] POS_TIME_0    = CNT_W'(4);
    localparam logic [CNT_W-1:0] POS_TIME_1    = CNT_W'(5);
    localparam logic [CNT_W-1:0] POS_TIME_2    = CNT_W'(6);
    localparam logic [CNT_W-1:0] POS_LAST      = CNT_W'(FRAME_LEN - 1);

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_DELIM = 2'd1,
        ST_BAD_CRC   = 2'd2
    } t_status;

    typedef struct packed {
        logic        done;
        t_status     status;
        logic [31:0] time_value;
        logic [15:0] received_crc;
        logic [15:0] computed_crc;
    } t_frame_result;

    // crc-16-ccitt, one byte, byte-wise shift/xor form
    function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] a;
        a = acc ^ {8'h00, b};
        a = {a[7:0], a[15:8]};
        a = a ^ ((a & CRC_HI_MASK) << 4);
        a = a ^ (a >> 12);
        a = a ^ ((a & CRC_HI_MASK) >> 5);
        return a;
    endfunction

endpackage

[sv/dfcc_collector.sv]
module dfcc_collector
    import dfcc_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_rx_byte,
    input  logic [7:0]    i_delimiter,
    output t_frame_result o_result
);

    logic             r_in_frame, n_in_frame;
    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_zero_byte, n_zero_byte;
    logic [15:0]      r_rcrc, n_rcrc;
    logic [23:0]      r_time, n_time;
    logic [15:0]      r_crc, n_crc;
    logic [15:0]      crc_in;
    logic [15:0]      crc_next;

    // crc restarts at the first time byte
    assign crc_in   = (r_count == POS_TIME_0) ? 16'h0000 : r_crc;
    assign crc_next = crc_step(crc_in, i_rx_byte);

    always_comb begin
        n_in_frame  = r_in_frame;
        n_count     = r_count;
        n_zero_byte = r_zero_byte;
        n_rcrc      = r_rcrc;
        n_time      = r_time;
        n_crc       = r_crc;

        o_result.done         = 1'b0;
        o_result.time_value   = {i_rx_byte, r_time};
        o_result.received_crc = r_rcrc;
        o_result.computed_crc = crc_next;
        if (r_zero_byte != 8'h00) begin
            o_result.status = ST_BAD_DELIM;
        end else if (crc_next != r_rcrc) begin
            o_result.status = ST_BAD_CRC;
        end else begin
            o_result.status = ST_OK;
        end

        if (i_accept) begin
            if (!r_in_frame) begin
                if (i_rx_byte == i_delimiter) begin
                    n_in_frame = 1'b1;
                    n_count    = CNT_W'(1);
                end
            end else begin
                n_count = r_count + CNT_W'(1);
                case (r_count)
                    POS_ZERO_BYTE: n_zero_byte  = i_rx_byte;
                    POS_CRC_LO:    n_rcrc[7:0]  = i_rx_byte;
                    POS_CRC_HI:    n_rcrc[15:8] = i_rx_byte;
                    POS_TIME_0: begin
                        n_time[7:0] = i_rx_byte;
                        n_crc       = crc_next;
                    end
                    POS_TIME_1: begin
                        n_time[15:8] = i_rx_byte;
                        n_crc        = crc_next;
                    end
                    POS_TIME_2: begin
                        n_time[23:16] = i_rx_byte;
                        n_crc         = crc_next;
                    end
                    POS_LAST: begin
                        o_result.done = 1'b1;
                        n_in_frame    = 1'b0;
                        n_count       = '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_count    <= '0;
        end else begin
            r_in_frame <= n_in_frame;
            r_count    <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_zero_byte <= n_zero_byte;
        r_rcrc      <= n_rcrc;
        r_time      <= n_time;
        r_crc       <= n_crc;
    end

    a_hunt_count_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_frame |-> r_count == '0)
        else $error("byte count not zero while hunting");

    a_drop_non_delim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !r_in_frame && i_rx_byte != i_delimiter) |=> !r_in_frame)
        else $error("frame started on a non-delimiter byte");

    a_done_at_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.done |-> (r_in_frame && r_count == POS_LAST && i_accept))
        else $error("frame completed at wrong byte");

endmodule

[sv/delimited_frame_crc_checker.sv]
// channel   direction  handshake                 payload
// in        request    i_in_valid / o_in_stall   i_rx_byte
// out       result     o_out_valid / i_out_stall o_frame_status, o_time_value,
//                                                o_received_crc, o_computed_crc
// cfg       write      i_cfg_we                  i_cfg_data (delimiter)
//
// one byte accepted per cycle while the input is not stalled; the crc advances one byte per accepted time byte
// the result appears in the output register the cycle after the eighth frame byte
// synchronous active-low reset: hunting, no result pending, delimiter back to '$'
// input stalls only while a result is held and the output side stalls
module delimited_frame_crc_checker
    import dfcc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_frame_status,
    output logic [31:0] o_time_value,
    output logic [15:0] o_received_crc,
    output logic [15:0] o_computed_crc,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data
);

    logic          r_out_valid, n_out_valid;
    t_status       r_status;
    logic [31:0]   r_time;
    logic [15:0]   r_rcrc;
    logic [15:0]   r_ccrc;
    logic [7:0]    r_delim;
    logic          in_accept;
    t_frame_result result;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    dfcc_collector u_collector (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_rx_byte   (i_rx_byte),
        .i_delimiter (r_delim),
        .o_result    (result)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (result.done) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_delim     <= DELIM_RESET;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_delim <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (result.done) begin
            r_status <= result.status;
            r_time   <= result.time_value;
            r_rcrc   <= result.received_crc;
            r_ccrc   <= result.computed_crc;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_frame_status = r_status;
    assign o_time_value   = r_time;
    assign o_received_crc = r_rcrc;
    assign o_computed_crc = r_ccrc;

    a_done_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        result.done |=> r_out_valid)
        else $error("completed frame did not reach the output register");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        result.done |-> !(r_out_valid && i_out_stall))
        else $error("pending result overwritten");

    a_ok_means_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_OK) |-> (r_rcrc == r_ccrc))
        else $error("ok status with crc mismatch");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (o_frame_status != 2'd3))
        else $error("illegal frame status");

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top
    import dfcc_pkg::*;
();

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_BYTES   = 260;
    localparam int NUM_PHASES    = 5;
    localparam int DIRECTED_LEN  = 26;

    typedef struct packed {
        t_status     status;
        logic [31:0] time_value;
        logic [15:0] received_crc;
        logic [15:0] computed_crc;
    } t_frame_report;

    typedef struct packed {
        logic [7:0]    rx;
        logic          typed;
        t_frame_report want;
    } t_stim_row;

    localparam t_frame_report NO_REPORT = '{ST_OK, 32'h0, 16'h0, 16'h0};

    // hunting noise, an all-zero good frame, a bad second byte with '$' inside
    // and all-ones time, then a crc mismatch
    localparam t_stim_row DIRECTED_ROWS [DIRECTED_LEN] = '{
        '{8'h00, 1'b0, NO_REPORT},
        '{8'hFF, 1'b0, NO_REPORT},
        '{8'h24, 1'b0, NO_REPORT},
        '{8'h00, 1'b0, NO_REPORT},
        '{8'h00, 1'b0, NO_REPORT},
        '{8'h00, 1'b0, NO_REPORT},
        '{8'h00, 1'b0, NO_REPORT},
        '{8'h00, 1'b0, NO_REPORT},
        '{8'h00, 1'b0, NO_REPORT},
        '{8'h00, 1'b1, '{ST_OK, 32'h0, 16'h0, 16'h0}},
        '{8'h24, 1'b0, NO_REPORT},
        '{8'hFF, 1'b0, NO_REPORT},
        '{8'h24, 1'b0, NO_REPORT},
        '{8'h24, 1'b0, NO_REPORT},
        '{8'hFF, 1'b0, NO_REPORT},
        '{8'hFF, 1'b0, NO_REPORT},
        '{8'hFF, 1'b0, NO_REPORT},
        '{8'hFF, 1'b0, NO_REPORT},
        '{8'h24, 1'b0, NO_REPORT},
        '{8'h00, 1'b0, NO_REPORT},
        '{8'h01, 1'b0, NO_REPORT},
        '{8'h00, 1'b0, NO_REPORT},
        '{8'h00, 1'b0, NO_REPORT},
        '{8'h00, 1'b0, NO_REPORT},
        '{8'h00, 1'b0, NO_REPORT},
        '{8'h00, 1'b1, '{ST_BAD_CRC, 32'h0, 16'h0001, 16'h0}}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_frame_status;
    logic [31:0] o_time_value;
    logic [15:0] o_received_crc;
    logic [15:0] o_computed_crc;
    logic        i_cfg_we = 1'b0;
    logic [7:0]  i_cfg_data = 8'h00;

    // frame tracker state
    logic [7:0]      hunt_delim;
    bit              collecting;
    int              fill_count;
    logic [7:0]      frame_bytes [FRAME_LEN];
    t_frame_report   pending_reports [$];

    int unsigned     cycle_count = 0;
    int unsigned     bytes_accepted = 0;
    int              mismatches = 0;
    bit              calm = 1'b0;

    delimited_frame_crc_checker u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_frame_status (o_frame_status),
        .o_time_value   (o_time_value),
        .o_received_crc (o_received_crc),
        .o_computed_crc (o_computed_crc),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ccitt update by one byte, init 0 form
    function automatic logic [15:0] ccitt_byte(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] x;
        logic [15:0] y;
        x = acc ^ {8'h00, b};
        y = {x[7:0], x[15:8]};
        y = y ^ {y[11:8], 12'h000};
        y = y ^ {12'h000, y[15:12]};
        y = y ^ {5'b00000, y[15:8], 3'b000};
        return y;
    endfunction

    function automatic logic [15:0] time_crc(input logic [31:0] t);
        logic [15:0] acc;
        acc = 16'h0000;
        for (int k = 0; k < 4; k++) begin
            acc = ccitt_byte(acc, t[8*k +: 8]);
        end
        return acc;
    endfunction

    // advance the frame tracker by one byte; returns 1 when a frame completes
    function automatic bit absorb_byte(input logic [7:0] b, output t_frame_report rep);
        rep = NO_REPORT;
        if (!collecting) begin
            if (b != hunt_delim) begin
                return 1'b0;
            end
            collecting = 1'b1;
            fill_count = 0;
        end
        frame_bytes[fill_count] = b;
        fill_count++;
        if (fill_count < FRAME_LEN) begin
            return 1'b0;
        end
        collecting = 1'b0;
        fill_count = 0;
        rep.received_crc = {frame_bytes[3], frame_bytes[2]};
        rep.time_value   = {frame_bytes[7], frame_bytes[6], frame_bytes[5], frame_bytes[4]};
        rep.computed_crc = time_crc(rep.time_value);
        if (frame_bytes[1] != 8'h00) begin
            rep.status = ST_BAD_DELIM;
        end else if (rep.computed_crc != rep.received_crc) begin
            rep.status = ST_BAD_CRC;
        end else begin
            rep.status = ST_OK;
        end
        return 1'b1;
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic typed, input t_frame_report want);
        int            gap;
        t_frame_report rep;
        if (!calm && $urandom_range(99) < 10) begin
            gap = $urandom_range(1, 4);
            repeat (gap) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                i_rx_byte  <= 8'($urandom);
            end
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_in_stall);
        bytes_accepted++;
        if (absorb_byte(b, rep)) begin
            pending_reports.push_back(typed ? want : rep);
        end
    endtask

    task automatic send_raw(input logic [7:0] b);
        push_byte(b, 1'b0, NO_REPORT);
    endtask

    // mostly well-formed frames with random content, some noise and cut-off frames
    task automatic send_frame();
        logic [31:0] t;
        logic [15:0] crc;
        logic [7:0]  zb;
        logic [7:0]  bytes [FRAME_LEN];
        int          n;
        int          keep;
        if ($urandom_range(99) < 25) begin
            n = $urandom_range(1, 3);
            repeat (n) send_raw(8'($urandom));
        end
        case ($urandom_range(19))
            0:       t = 32'h0000_0000;
            1:       t = 32'hFFFF_FFFF;
            default: t = $urandom;
        endcase
        zb  = ($urandom_range(99) < 85) ? 8'h00 : 8'($urandom_range(1, 255));
        crc = ($urandom_range(99) < 70) ? time_crc(t) : 16'($urandom);
        bytes[0] = hunt_delim;
        bytes[1] = zb;
        bytes[2] = crc[7:0];
        bytes[3] = crc[15:8];
        bytes[4] = t[7:0];
        bytes[5] = t[15:8];
        bytes[6] = t[23:16];
        bytes[7] = t[31:24];
        keep = ($urandom_range(99) < 8) ? $urandom_range(1, FRAME_LEN - 1) : FRAME_LEN;
        for (int k = 0; k < keep; k++) begin
            send_raw(bytes[k]);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_delimiter(input logic [7:0] d);
        drain();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= d;
        @(posedge i_clk);
        hunt_delim = d;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    always @(negedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(99) < 10);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_frame_report want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected result: status %0d time %h rcrc %h ccrc %h",
                         $time, o_frame_status, o_time_value, o_received_crc,
                         o_computed_crc);
                mismatches++;
            end else begin
                want = pending_reports.pop_front();
                if (o_frame_status !== want.status) begin
                    $display("%0t: frame_status expected %0d actual %0d",
                             $time, want.status, o_frame_status);
                    mismatches++;
                end
                if (o_time_value !== want.time_value) begin
                    $display("%0t: time_value expected %h actual %h",
                             $time, want.time_value, o_time_value);
                    mismatches++;
                end
                if (o_received_crc !== want.received_crc) begin
                    $display("%0t: received_crc expected %h actual %h",
                             $time, want.received_crc, o_received_crc);
                    mismatches++;
                end
                if (o_computed_crc !== want.computed_crc) begin
                    $display("%0t: computed_crc expected %h actual %h",
                             $time, want.computed_crc, o_computed_crc);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        logic [7:0] phase_delim;
        int unsigned phase_start;
        hunt_delim = DELIM_RESET;
        collecting = 1'b0;
        fill_count = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_LEN; i++) begin
            push_byte(DIRECTED_ROWS[i].rx, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
        end

        // phase 0 keeps the reset delimiter; phase 2 runs with no idling
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                1:       phase_delim = 8'h00;
                2:       phase_delim = 8'hFF;
                3:       phase_delim = 8'($urandom_range(1, 254));
                default: phase_delim = DELIM_RESET;
            endcase
            if (p > 0) begin
                set_delimiter(phase_delim);
            end
            calm = (p == 2);
            phase_start = bytes_accepted;
            while (bytes_accepted - phase_start < PHASE_BYTES) send_frame();
        end
        calm = 1'b0;

        drain();
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
